### src/ct3_pkg.sv
// ----------------------------------------------------------------------------
// ct3_pkg
// shared types and constants of the 3x3 census transform
// ----------------------------------------------------------------------------
package ct3_pkg;

    localparam int DEF_MAX_WIDTH   = 1024;
    localparam int DEF_PIXEL_BITS  = 8;

    localparam int CFG_INDEX_BITS  = 1;
    localparam int CFG_DATA_BITS   = 12;
    localparam int WIDTH_REG_BITS  = 11;
    localparam int HEIGHT_REG_BITS = 12;

    localparam logic [WIDTH_REG_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_REG_BITS-1:0] HEIGHT_RESET = 12'd480;
    localparam int MIN_SIDE = 3;

    localparam int CODE_BITS       = 8;
    localparam int ROW_BITS        = 12;
    localparam int CENTRE_COL_BITS = 10;

    localparam int OUT_QUEUE_DEPTH = 3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CODE_BITS-1:0]       census_code;
        logic [ROW_BITS-1:0]        centre_row;
        logic [CENTRE_COL_BITS-1:0] centre_col;
        logic                       frame_last;
    } t_result;

endpackage

### src/ct3_ram.sv
// ----------------------------------------------------------------------------
// ct3_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ct3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/census_transform_3x3.sv
// ----------------------------------------------------------------------------
// census_transform_3x3
// 3x3 census transform over a raster-order pixel stream
// ----------------------------------------------------------------------------
// Takes one pixel per clock with no gaps of its own. A pixel is accepted, its
// column is read from the two line stores (registered read), and in the
// following cycle the window shifts, the line stores are written back and the
// census code of the interior centre is pushed into a three-word output queue.
// o_stall rises only when the output queue cannot take another word, i.e. when
// the downstream side holds i_stall. Line stores need no clearing after reset:
// their unwritten entries only feed border positions, which give no word.
// Register writes take effect at once and leave the counters untouched.
// ----------------------------------------------------------------------------
module census_transform_3x3 #(
    parameter int MAX_WIDTH  = ct3_pkg::DEF_MAX_WIDTH,
    parameter int PIXEL_BITS = ct3_pkg::DEF_PIXEL_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ct3_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic [ct3_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [PIXEL_BITS-1:0]               i_pixel,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ct3_pkg::CODE_BITS-1:0]       o_census_code,
    output logic [ct3_pkg::ROW_BITS-1:0]        o_centre_row,
    output logic [ct3_pkg::CENTRE_COL_BITS-1:0] o_centre_col,
    output logic                                o_frame_last
);

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WRB    = ct3_pkg::WIDTH_REG_BITS;
    localparam int HRB    = ct3_pkg::HEIGHT_REG_BITS;
    localparam int EW     = (WRB > COL_W + 1) ? WRB : COL_W + 1;
    localparam int RW     = ct3_pkg::ROW_BITS;
    localparam int OCW    = ct3_pkg::CENTRE_COL_BITS;
    localparam int QD     = ct3_pkg::OUT_QUEUE_DEPTH;
    localparam int QPW    = $clog2(QD);
    localparam int QCW    = $clog2(QD + 1);

    // configuration
    logic [WRB-1:0] r_width;
    logic [HRB-1:0] r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= ct3_pkg::WIDTH_RESET;
            r_height <= ct3_pkg::HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (ct3_pkg::t_cfg_reg'(i_cfg_index))
                ct3_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[WRB-1:0];
                ct3_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data[HRB-1:0];
                default: ;
            endcase
        end
    end

    logic [EW-1:0]  eff_width;
    logic [HRB-1:0] eff_height;
    logic [EW-1:0]  width_ext;

    always_comb begin
        width_ext = EW'(r_width);
        if (width_ext < EW'(ct3_pkg::MIN_SIDE)) begin
            eff_width = EW'(ct3_pkg::MIN_SIDE);
        end else if (width_ext > EW'(MAX_WIDTH)) begin
            eff_width = EW'(MAX_WIDTH);
        end else begin
            eff_width = width_ext;
        end
        if (r_height < HRB'(ct3_pkg::MIN_SIDE)) begin
            eff_height = HRB'(ct3_pkg::MIN_SIDE);
        end else begin
            eff_height = r_height;
        end
    end

    // input side: counters and line store read
    logic [COL_W-1:0] r_col;
    logic [RW-1:0]    r_row;
    logic             in_accept;
    logic             line_end;
    logic             frame_end;
    logic             emit;
    logic [COL_W-1:0] col_m1;

    assign in_accept = i_valid && !o_stall;
    assign line_end  = EW'(r_col) >= (eff_width - EW'(1));
    assign frame_end = line_end && (RW'(r_row) >= RW'(eff_height - HRB'(1)));
    assign emit      = (r_row >= RW'(2)) && (EW'(r_col) >= EW'(2));
    assign col_m1    = r_col - COL_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (line_end) begin
                r_col <= '0;
                r_row <= frame_end ? '0 : r_row + RW'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // second stage: window shift, write-back, code
    logic                  r_s1_valid;
    logic                  r_s1_emit;
    logic [PIXEL_BITS-1:0] r_s1_pixel;
    logic [COL_W-1:0]      r_s1_addr;
    logic [RW-1:0]         r_s1_row;
    logic [OCW-1:0]        r_s1_col;
    logic                  r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_emit  <= 1'b0;
        end else begin
            r_s1_valid <= in_accept;
            r_s1_emit  <= in_accept && emit;
        end
        if (in_accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_addr  <= r_col;
            r_s1_row   <= r_row - RW'(1);
            r_s1_col   <= OCW'(col_m1);
            r_s1_last  <= frame_end;
        end
    end

    logic [PIXEL_BITS-1:0] rd_a;
    logic [PIXEL_BITS-1:0] rd_b;

    ct3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_a (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (r_s1_pixel),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (rd_a)
    );

    ct3_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_line_b (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_addr),
        .i_wdata (rd_a),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (rd_b)
    );

    logic [PIXEL_BITS-1:0] r_win [9];
    logic [PIXEL_BITS-1:0] n_win [9];
    logic [ct3_pkg::CODE_BITS-1:0] code;

    always_comb begin
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = rd_b;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = rd_a;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_s1_pixel;
        code = {n_win[0] < n_win[4], n_win[1] < n_win[4], n_win[2] < n_win[4],
                n_win[3] < n_win[4], n_win[5] < n_win[4], n_win[6] < n_win[4],
                n_win[7] < n_win[4], n_win[8] < n_win[4]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_s1_valid) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
        end
    end

    // output word queue
    ct3_pkg::t_result r_queue [QD];
    logic [QPW-1:0]   r_wr_ptr;
    logic [QPW-1:0]   r_rd_ptr;
    logic [QCW-1:0]   r_count;
    logic             push;
    logic             pop;
    ct3_pkg::t_result head;

    assign push = r_s1_valid && r_s1_emit;
    assign pop  = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPW'(QD - 1)) ? '0 : r_wr_ptr + QPW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPW'(QD - 1)) ? '0 : r_rd_ptr + QPW'(1);
            end
            r_count <= r_count + QCW'(push) - QCW'(pop);
        end
        if (push) begin
            r_queue[r_wr_ptr] <= '{census_code: code, centre_row: r_s1_row,
                                   centre_col: r_s1_col, frame_last: r_s1_last};
        end
    end

    assign head          = r_queue[r_rd_ptr];
    assign o_valid       = (r_count != '0);
    assign o_census_code = head.census_code;
    assign o_centre_row  = head.centre_row;
    assign o_centre_col  = head.centre_col;
    assign o_frame_last  = head.frame_last;
    assign o_stall       = ((QCW + 1)'(r_count) + (QCW + 1)'(push)) >= (QCW + 1)'(QD);

`ifndef SYNTHESIS
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (r_count < QCW'(QD)))
        else $error("output queue overflow");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && in_accept) |-> (r_s1_addr != r_col))
        else $error("line store read and write-back hit the same column");

    a_code_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_valid)
        else $error("pushed word not visible at output");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |-> (EW'(r_col) < EW'(MAX_WIDTH)))
        else $error("column counter beyond line store depth");
`endif

endmodule

### verif/census_transform_3x3_tb.sv
// ----------------------------------------------------------------------------
// census_transform_3x3_tb
// self-checking bench for the 3x3 census transform
// ----------------------------------------------------------------------------
// Streams pixels through the block under random gaps and back-pressure.
// Every accepted pixel also steps a software copy of the line stores,
// the window and the raster counters. The code, centre position and
// end-of-frame flag that it gives are queued, and each word leaving the
// block is compared field by field with the oldest queued one.
// A short table of hand-built frames comes first. Scripted runs follow:
// the tallest frame cut short by a mid-frame height write, and a
// mid-line width shrink. Random frame sizes and pixel patterns make up
// the rest.
// ----------------------------------------------------------------------------
module census_transform_3x3_tb;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_PIXELS = 400;
    localparam int PIX_BITS      = ct3_pkg::DEF_PIXEL_BITS;
    localparam int MAX_W         = ct3_pkg::DEF_MAX_WIDTH;
    localparam int ROW_W         = ct3_pkg::ROW_BITS;
    localparam int COL_W         = ct3_pkg::CENTRE_COL_BITS;
    localparam int CODE_W        = ct3_pkg::CODE_BITS;
    localparam int CFG_IW        = ct3_pkg::CFG_INDEX_BITS;
    localparam int CFG_DW        = ct3_pkg::CFG_DATA_BITS;
    localparam int MAX_HEIGHT    = (1 << ROW_W) - 1;

    typedef enum logic [1:0] {
        PAT_NOISE,
        PAT_FLAT,
        PAT_RAMP,
        PAT_EXTREME
    } t_pattern;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel;
        logic                typed;
        ct3_pkg::t_result    word;
    } t_stim_row;

    localparam ct3_pkg::t_result NO_WORD     = '0;
    localparam ct3_pkg::t_result WORD_ALL_LT = {8'hFF, 12'd1, 10'd1, 1'b1};
    localparam ct3_pkg::t_result WORD_CORNER = {8'h81, 12'd1, 10'd1, 1'b1};

    // two 3x3 frames: every neighbour below the centre, then only two opposite corners
    t_stim_row directed_rows [18] = '{
        {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD}, {8'hFF, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD},
        {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b0, NO_WORD}, {8'h00, 1'b1, WORD_ALL_LT},
        {8'h00, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
        {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD},
        {8'h80, 1'b0, NO_WORD}, {8'h80, 1'b0, NO_WORD}, {8'h7F, 1'b1, WORD_CORNER}
    };

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [CFG_IW-1:0]   i_cfg_index = '0;
    logic [CFG_DW-1:0]   i_cfg_data  = '0;
    logic                i_valid     = 1'b0;
    logic                o_stall;
    logic [PIX_BITS-1:0] i_pixel     = '0;
    logic                o_valid;
    logic                i_stall     = 1'b0;
    logic [CODE_W-1:0]   o_census_code;
    logic [ROW_W-1:0]    o_centre_row;
    logic [COL_W-1:0]    o_centre_col;
    logic                o_frame_last;

    // shadow of the block state
    logic [ct3_pkg::WIDTH_REG_BITS-1:0]  reg_width  = ct3_pkg::WIDTH_RESET;
    logic [ct3_pkg::HEIGHT_REG_BITS-1:0] reg_height = ct3_pkg::HEIGHT_RESET;
    logic [PIX_BITS-1:0]        prev_line  [MAX_W];
    logic [PIX_BITS-1:0]        older_line [MAX_W];
    logic [PIX_BITS-1:0]        window     [9];
    int unsigned                col_count  = 0;
    int unsigned                row_count  = 0;

    ct3_pkg::t_result           census_words_due [$];
    logic [PIX_BITS-1:0]        pattern_level = '0;
    bit                         sender_eager  = 1'b0;
    bit                         sink_eager    = 1'b0;
    int                         mismatch_count = 0;
    int                         words_checked  = 0;
    int                         pixels_sent    = 0;
    int                         size_settings  = 0;
    int                         cycle_count    = 0;

    census_transform_3x3 dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_census_code (o_census_code),
        .o_centre_row  (o_centre_row),
        .o_centre_col  (o_centre_col),
        .o_frame_last  (o_frame_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int unsigned eff_width();
        if (reg_width < ct3_pkg::MIN_SIDE) return ct3_pkg::MIN_SIDE;
        if (reg_width > MAX_W) return MAX_W;
        return reg_width;
    endfunction

    function automatic int unsigned eff_height();
        if (reg_height < ct3_pkg::MIN_SIDE) return ct3_pkg::MIN_SIDE;
        if (reg_height > MAX_HEIGHT) return MAX_HEIGHT;
        return reg_height;
    endfunction

    task automatic census_of_pixel(input logic [PIX_BITS-1:0] px, output bit has_word,
                                   output ct3_pkg::t_result word);
        int unsigned         w;
        int unsigned         h;
        int unsigned         idx;
        bit                  line_end;
        bit                  frame_end;
        logic [PIX_BITS-1:0] centre;
        logic [CODE_W-1:0]   code;
        w   = eff_width();
        h   = eff_height();
        idx = (col_count >= MAX_W) ? MAX_W - 1 : col_count;
        for (int r = 0; r < 3; r++) begin
            window[r*3]   = window[r*3+1];
            window[r*3+1] = window[r*3+2];
        end
        window[2]       = older_line[idx];
        window[5]       = prev_line[idx];
        window[8]       = px;
        older_line[idx] = prev_line[idx];
        prev_line[idx]  = px;
        line_end  = (col_count + 1 >= w);
        frame_end = line_end && (row_count + 1 >= h);
        has_word  = (row_count >= 2) && (col_count >= 2);
        word      = NO_WORD;
        if (has_word) begin
            centre = window[4];
            code   = '0;
            for (int k = 0; k < 9; k++) begin
                if (k != 4) code = {code[CODE_W-2:0], window[k] < centre};
            end
            word.census_code = code;
            word.centre_row  = ROW_W'(row_count - 1);
            word.centre_col  = COL_W'(col_count - 1);
            word.frame_last  = frame_end;
        end
        if (line_end) begin
            col_count = 0;
            row_count = frame_end ? 0 : ((row_count + 1) & MAX_HEIGHT);
        end else begin
            col_count = (col_count + 1) & (MAX_W - 1);
        end
    endtask

    function automatic logic [PIX_BITS-1:0] next_pixel(input t_pattern pattern);
        case (pattern)
            PAT_FLAT:    return pattern_level ^ PIX_BITS'($urandom_range(0, 1));
            PAT_RAMP: begin
                pattern_level = pattern_level + PIX_BITS'($urandom_range(0, 3));
                return pattern_level;
            end
            PAT_EXTREME: return $urandom_range(0, 1) ? '1 : '0;
            default:     return PIX_BITS'($urandom);
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_BITS-1:0] px, input bit typed,
                              input ct3_pkg::t_result typed_word);
        int               gap;
        bit               hold_off;
        bit               has_word;
        ct3_pkg::t_result word;
        gap      = sender_eager ? 0 : $urandom_range(0, 7);
        hold_off = !sender_eager && ($urandom_range(0, 63) == 0);
        if (gap > 0 || hold_off) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            if (hold_off) begin
                do @(posedge i_clk); while (census_words_due.size() != 0);
            end
        end
        i_valid <= 1'b1;
        i_pixel <= px;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        census_of_pixel(px, has_word, word);
        if (typed) census_words_due = {census_words_due, typed_word};
        else if (has_word) census_words_due = {census_words_due, word};
        pixels_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (census_words_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_size(input logic [CFG_DW-1:0] width_data, height_data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ct3_pkg::REG_IMAGE_WIDTH;
        i_cfg_data  <= width_data;
        @(posedge i_clk);
        reg_width    = width_data[ct3_pkg::WIDTH_REG_BITS-1:0];
        i_cfg_index <= ct3_pkg::REG_IMAGE_HEIGHT;
        i_cfg_data  <= height_data;
        @(posedge i_clk);
        reg_height   = height_data[ct3_pkg::HEIGHT_REG_BITS-1:0];
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
        size_settings++;
    endtask

    task automatic send_frames(input int frames, input t_pattern pattern);
        int unsigned w;
        int unsigned h;
        int unsigned left;
        repeat (frames) begin
            w    = eff_width();
            h    = eff_height();
            left = (col_count + 1 >= w) ? 1 : w - col_count;
            if (row_count + 1 < h) left += (h - 1 - row_count) * w;
            repeat (left) push_pixel(next_pixel(pattern), 1'b0, NO_WORD);
        end
    endtask

    initial begin : sink
        int               hold;
        ct3_pkg::t_result got;
        ct3_pkg::t_result want;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            hold = sink_eager ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            got = {o_census_code, o_centre_row, o_centre_col, o_frame_last};
            if (census_words_due.size() == 0) begin
                $error("census word %h with none due", got);
                mismatch_count++;
            end else begin
                want = census_words_due.pop_front();
                words_checked++;
                if (got.census_code !== want.census_code) begin
                    $error("census_code expected %h got %h", want.census_code, got.census_code);
                    mismatch_count++;
                end
                if (got.centre_row !== want.centre_row) begin
                    $error("centre_row expected %0d got %0d", want.centre_row, got.centre_row);
                    mismatch_count++;
                end
                if (got.centre_col !== want.centre_col) begin
                    $error("centre_col expected %0d got %0d", want.centre_col, got.centre_col);
                    mismatch_count++;
                end
                if (got.frame_last !== want.frame_last) begin
                    $error("frame_last expected %b got %b", want.frame_last, got.frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : source
        int                first_random;
        int                w;
        int                h;
        logic [CFG_DW-1:0] width_data;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // both registers below range, so the frame is the smallest 3x3
        program_size(12'd0, 12'd1);
        foreach (directed_rows[i]) begin
            push_pixel(directed_rows[i].pixel, directed_rows[i].typed, directed_rows[i].word);
        end
        settle();

        // tallest frame, cut short by a height write mid-frame
        program_size(12'd3, 12'hFFF);
        repeat (20 * 3) push_pixel(next_pixel(PAT_NOISE), 1'b0, NO_WORD);
        settle();
        program_size(12'd3, 12'd0);
        send_frames(1, PAT_NOISE);
        settle();

        // width shrunk mid-line so that the current column becomes the last of the line
        program_size(12'd9, 12'd6);
        repeat (13) push_pixel(next_pixel(PAT_EXTREME), 1'b0, NO_WORD);
        settle();
        program_size(12'd5, 12'd6);
        send_frames(1, PAT_NOISE);
        settle();

        first_random = pixels_sent;
        while (pixels_sent - first_random < RANDOM_PIXELS) begin
            case ($urandom_range(0, 7))
                0:       w = $urandom_range(0, 2);
                1:       w = $urandom_range(13, 40);
                default: w = $urandom_range(3, 12);
            endcase
            h = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            width_data     = CFG_DW'(w);
            width_data[11] = $urandom_range(0, 1);
            program_size(width_data, CFG_DW'(h));
            sender_eager  = ($urandom_range(0, 3) == 0);
            sink_eager    = ($urandom_range(0, 3) == 0);
            pattern_level = PIX_BITS'($urandom);
            send_frames($urandom_range(1, 3), t_pattern'($urandom_range(0, 3)));
            settle();
        end

        $display("%0d pixels sent, %0d census words checked, %0d size settings",
                 pixels_sent, words_checked, size_settings);
        $display("frames from 3x3 up to 40 wide, a 4095-line frame cut short, a mid-line"
                 , " shrink, noise, flat, ramp and extreme images");
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
